// ===== rtl/core/cpds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core power domain sequencer package
// Shared constants, control bit positions and the result record.
// ----------------------------------------------------------------------------
package cpds_pkg;

    localparam int NUM_CORES  = 4;
    localparam int SLOTS      = 4;
    localparam int LIVE_CORES = (NUM_CORES < SLOTS) ? NUM_CORES : SLOTS;

    localparam int CORE_W  = 2;
    localparam int COUNT_W = 16;
    localparam int SETTLE_W = 8;

    localparam int B_RST_B    = 0;
    localparam int B_ISO      = 1;
    localparam int B_ON       = 2;
    localparam int B_ON2      = 3;
    localparam int B_CLKDIS   = 4;
    localparam int B_CKISO    = 5;
    localparam int B_ISOINT_B = 6;
    localparam int B_L1PDN    = 7;

    localparam logic [7:0] CTRL_RESET = 8'hB2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [7:0]  SETTLE_RESET  = 8'd1;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_SETTLE  = 1'b1;

    localparam logic [2:0] OUT_NONE     = 3'd0;
    localparam logic [2:0] OUT_DONE     = 3'd1;
    localparam logic [2:0] OUT_BAD_CORE = 3'd2;
    localparam logic [2:0] OUT_ACK1_TO  = 3'd3;
    localparam logic [2:0] OUT_ACK2_TO  = 3'd4;
    localparam logic [2:0] OUT_L1_TO    = 3'd5;

    typedef struct packed {
        logic [31:0]       control_word;
        logic              busy_res;
        logic [CORE_W-1:0] active_core;
        logic [2:0]        outcome;
    } res_t;

endpackage

// ===== rtl/core/cpds_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core power domain sequencer state
// Holds the setup registers, phase, wait counter and per-core control bits,
// and forms the result of the current request.
// ----------------------------------------------------------------------------
module cpds_seq
    import cpds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                step,
    input  logic                mode,
    input  logic [7:0]          core,
    input  logic [3:0]          first_ack,
    input  logic [3:0]          second_ack,
    input  logic [3:0]          l1_ack,
    output res_t                result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE1,
        PH_ACK1,
        PH_ACK2,
        PH_L1,
        PH_SETTLE2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CORE_W-1:0]   current_core_reg, current_core_next;
    logic [COUNT_W-1:0]  wait_count_reg, wait_count_next;
    logic [7:0]          ctrl_reg [SLOTS];
    logic [7:0]          ctrl_next [SLOTS];
    logic [15:0]         timeout_reg;
    logic [7:0]          settle_reg;

    logic [COUNT_W-1:0]  count_inc;
    logic [COUNT_W-1:0]  timeout_lim;
    logic [COUNT_W-1:0]  settle_lim;
    logic                expired;
    logic                settled;
    logic [7:0]          cur_bits;
    logic [2:0]          outcome;

    assign count_inc   = wait_count_reg + 16'd1;
    assign timeout_lim = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign settle_lim  = (settle_reg == 8'd0) ? 16'd1 : {8'd0, settle_reg};
    assign expired     = count_inc >= timeout_lim;
    assign settled     = count_inc >= settle_lim;
    assign cur_bits    = ctrl_reg[current_core_reg];

    always_comb
    begin
        phase_next        = phase_reg;
        current_core_next = current_core_reg;
        wait_count_next   = wait_count_reg;
        outcome           = OUT_NONE;
        for (int i = 0; i < SLOTS; i++)
        begin
            ctrl_next[i] = ctrl_reg[i];
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (mode)
                begin
                    if (core >= 8'(LIVE_CORES))
                    begin
                        outcome = OUT_BAD_CORE;
                    end
                    else
                    begin
                        current_core_next = core[CORE_W-1:0];
                        ctrl_next[core[CORE_W-1:0]][B_ON] = 1'b1;
                        wait_count_next = '0;
                        phase_next = PH_SETTLE1;
                    end
                end
            end
            PH_SETTLE1:
            begin
                wait_count_next = count_inc;
                if (settled)
                begin
                    ctrl_next[current_core_reg] = cur_bits | (8'd1 << B_ON2);
                    wait_count_next = '0;
                    phase_next = PH_ACK1;
                end
            end
            PH_ACK1:
            begin
                if (first_ack[current_core_reg])
                begin
                    wait_count_next = '0;
                    phase_next = PH_ACK2;
                end
                else
                begin
                    wait_count_next = count_inc;
                    if (expired)
                    begin
                        outcome = OUT_ACK1_TO;
                        wait_count_next = '0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_ACK2:
            begin
                if (second_ack[current_core_reg])
                begin
                    ctrl_next[current_core_reg] =
                        cur_bits & ~((8'd1 << B_ISO) | (8'd1 << B_L1PDN));
                    wait_count_next = '0;
                    phase_next = PH_L1;
                end
                else
                begin
                    wait_count_next = count_inc;
                    if (expired)
                    begin
                        outcome = OUT_ACK2_TO;
                        wait_count_next = '0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_L1:
            begin
                if (!l1_ack[current_core_reg])
                begin
                    wait_count_next = '0;
                    phase_next = PH_SETTLE2;
                end
                else
                begin
                    wait_count_next = count_inc;
                    if (expired)
                    begin
                        outcome = OUT_L1_TO;
                        wait_count_next = '0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_SETTLE2:
            begin
                wait_count_next = count_inc;
                if (settled)
                begin
                    ctrl_next[current_core_reg] =
                        (cur_bits | (8'd1 << B_ISOINT_B) | (8'd1 << B_RST_B))
                        & ~((8'd1 << B_CKISO) | (8'd1 << B_CLKDIS));
                    outcome = OUT_DONE;
                    wait_count_next = '0;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                wait_count_next = '0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            result.control_word[8*i +: 8] = ctrl_next[i];
        end
        result.busy_res    = phase_next != PH_IDLE;
        result.active_core = current_core_next;
        result.outcome     = outcome;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            current_core_reg <= '0;
            wait_count_reg   <= '0;
            timeout_reg      <= TIMEOUT_RESET;
            settle_reg       <= SETTLE_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                ctrl_reg[i] <= CTRL_RESET;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TIMEOUT)
                begin
                    timeout_reg <= cfg_data;
                end
                else
                begin
                    settle_reg <= cfg_data[SETTLE_W-1:0];
                end
            end
            if (step)
            begin
                phase_reg        <= phase_next;
                current_core_reg <= current_core_next;
                wait_count_reg   <= wait_count_next;
                for (int i = 0; i < SLOTS; i++)
                begin
                    ctrl_reg[i] <= ctrl_next[i];
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> ({1'b0, current_core_reg} < (CORE_W+1)'(LIVE_CORES)))
        else $error("busy on a core beyond the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && !mode) |=> (phase_reg == PH_IDLE))
        else $error("sequence started without a request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.outcome == OUT_DONE) |-> (phase_reg == PH_SETTLE2))
        else $error("done reported outside final settle");

endmodule

// ===== rtl/core/cpds_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core power domain sequencer result buffer
// Output register with a skid entry so a request is taken while a result
// waits downstream.
// ----------------------------------------------------------------------------
module cpds_out
    import cpds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  res_t  push_data,
    output logic  full,
    input  logic  out_stall,
    output logic  out_valid,
    output res_t  out_data
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (push)
        begin
            if (!main_valid_reg || take)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_next       = skid_reg;
            main_valid_next = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not advanced");

endmodule

// ===== rtl/core/core_power_domain_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core power domain sequencer
// Steps the power-up order of one core per tick and reports control bits.
// ----------------------------------------------------------------------------
// One request is one tick and yields one result, which is registered in the
// output buffer. A request is taken every cycle while in_stall is low;
// in_stall rises only when two results are held because the output side
// stalls. Setup registers: index 0 timeout_ticks, index 1 settle_ticks,
// written at any time with cfg_ready always high.
module core_power_domain_sequencer
    import cpds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [7:0]          core,
    input  logic [3:0]          first_ack,
    input  logic [3:0]          second_ack,
    input  logic [3:0]          l1_ack,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         control_word,
    output logic                busy_res,
    output logic [CORE_W-1:0]   active_core,
    output logic [2:0]          outcome
);

    logic full;
    logic step;
    res_t step_res;
    res_t out_res;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign step      = in_valid && !full;

    cpds_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step       (step),
        .mode       (mode),
        .core       (core),
        .first_ack  (first_ack),
        .second_ack (second_ack),
        .l1_ack     (l1_ack),
        .result     (step_res)
    );

    cpds_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_data  (step_res),
        .full       (full),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_data   (out_res)
    );

    assign control_word = out_res.control_word;
    assign busy_res     = out_res.busy_res;
    assign active_core  = out_res.active_core;
    assign outcome      = out_res.outcome;

endmodule

// ===== sim/tb_core_power_domain_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core power domain sequencer testbench
// Drives ticks with start requests and ack bits through the request channel,
// predicts each tick's status word, busy flag, core and outcome, and checks
// every result in order. A directed table covers reset values, bad cores,
// requests while busy and repeated starts; random phases then sweep the
// timeout and settle registers (zero and both extremes included) with ack
// patterns biased toward or away from the running core.
// ----------------------------------------------------------------------------
module tb_core_power_domain_sequencer;
    import cpds_pkg::*;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SETTLE_ON,
        SEQ_WAIT_ACK1,
        SEQ_WAIT_ACK2,
        SEQ_WAIT_L1,
        SEQ_SETTLE_RST
    } seq_state_t;

    typedef struct {
        logic       mode;
        logic [7:0] core;
        logic [3:0] a1;
        logic [3:0] a2;
        logic [3:0] l1;
        bit         typed;
        res_t       want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES        = 5;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [15:0]       cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              mode;
    logic [7:0]        core;
    logic [3:0]        first_ack;
    logic [3:0]        second_ack;
    logic [3:0]        l1_ack;
    logic              out_valid;
    logic              out_stall;
    logic [31:0]       control_word;
    logic              busy_res;
    logic [CORE_W-1:0] active_core;
    logic [2:0]        outcome;

    // predictor state
    logic [15:0]       timeout_reg = TIMEOUT_RESET;
    logic [7:0]        settle_reg  = SETTLE_RESET;
    seq_state_t        seq_state   = SEQ_IDLE;
    logic [1:0]        seq_core    = 2'd0;
    logic [15:0]       seq_wait    = 16'd0;
    logic [7:0]        ctrl_bits [SLOTS] = '{default: CTRL_RESET};

    res_t              pending_status_q [$];
    int                mismatch_count = 0;
    bit                quiet = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 8'd0,   4'h0, 4'h0, 4'h0, 1'b1, '{32'hB2B2B2B2, 1'b0, 2'd0, OUT_NONE}},
        '{1'b1, 8'd255, 4'hF, 4'hF, 4'hF, 1'b1, '{32'hB2B2B2B2, 1'b0, 2'd0, OUT_BAD_CORE}},
        '{1'b1, 8'd4,   4'h0, 4'h0, 4'h0, 1'b1, '{32'hB2B2B2B2, 1'b0, 2'd0, OUT_BAD_CORE}},
        '{1'b1, 8'd3,   4'h0, 4'h0, 4'hF, 1'b0, '0},
        '{1'b1, 8'd0,   4'h0, 4'h0, 4'h0, 1'b0, '0},
        '{1'b1, 8'd200, 4'h7, 4'h0, 4'h0, 1'b0, '0},
        '{1'b0, 8'd0,   4'h8, 4'h0, 4'h0, 1'b0, '0},
        '{1'b0, 8'd0,   4'hF, 4'h7, 4'hF, 1'b0, '0},
        '{1'b0, 8'd0,   4'hF, 4'h8, 4'hF, 1'b0, '0},
        '{1'b0, 8'd0,   4'h0, 4'h0, 4'h8, 1'b0, '0},
        '{1'b0, 8'd0,   4'h0, 4'h0, 4'h7, 1'b0, '0},
        '{1'b1, 8'd1,   4'h0, 4'h0, 4'h0, 1'b0, '0},
        '{1'b1, 8'd3,   4'hF, 4'hF, 4'h0, 1'b0, '0},
        '{1'b0, 8'd0,   4'hF, 4'hF, 4'h0, 1'b0, '0},
        '{1'b0, 8'd0,   4'hF, 4'hF, 4'h0, 1'b0, '0},
        '{1'b0, 8'd0,   4'hF, 4'hF, 4'h0, 1'b0, '0},
        '{1'b0, 8'd0,   4'hF, 4'hF, 4'h0, 1'b0, '0},
        '{1'b0, 8'd0,   4'hF, 4'hF, 4'h0, 1'b0, '0},
        '{1'b1, 8'd0,   4'hF, 4'hF, 4'hE, 1'b0, '0},
        '{1'b0, 8'd0,   4'h1, 4'h1, 4'hE, 1'b0, '0},
        '{1'b0, 8'd0,   4'h1, 4'h1, 4'hE, 1'b0, '0},
        '{1'b0, 8'd0,   4'h1, 4'h1, 4'hE, 1'b0, '0},
        '{1'b0, 8'd0,   4'h1, 4'h1, 4'hE, 1'b0, '0},
        '{1'b0, 8'd0,   4'h1, 4'h1, 4'hE, 1'b0, '0},
        '{1'b0, 8'd0,   4'h0, 4'h0, 4'h0, 1'b0, '0}
    };

    int unsigned timeout_set [PHASES] = '{1, 0, 4, 65535, 12};
    int unsigned settle_set  [PHASES] = '{1, 0, 3, 255, 2};
    int unsigned count_set   [PHASES] = '{250, 150, 300, 560, 290};
    int unsigned bias_set    [PHASES] = '{50, 40, 30, 75, 85};
    bit          quiet_set   [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    core_power_domain_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .core         (core),
        .first_ack    (first_ack),
        .second_ack   (second_ack),
        .l1_ack       (l1_ack),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .control_word (control_word),
        .busy_res     (busy_res),
        .active_core  (active_core),
        .outcome      (outcome)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 80)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // count one tick of a wait; zero limit behaves as one
    function automatic bit wait_expired(input logic [15:0] limit);
        logic [15:0] lim;
        lim = (limit == 16'd0) ? 16'd1 : limit;
        seq_wait = seq_wait + 16'd1;
        return seq_wait >= lim;
    endfunction

    function automatic res_t step_power_sequence(input logic m, input logic [7:0] c,
                                                 input logic [3:0] a1, input logic [3:0] a2,
                                                 input logic [3:0] l1);
        res_t       r;
        logic [1:0] k;
        logic [2:0] result;
        k      = seq_core;
        result = OUT_NONE;
        case (seq_state)
            SEQ_IDLE:
            begin
                if (m)
                begin
                    if (c >= LIVE_CORES)
                    begin
                        result = OUT_BAD_CORE;
                    end
                    else
                    begin
                        seq_core = c[1:0];
                        ctrl_bits[c[1:0]][B_ON] = 1'b1;
                        seq_wait  = 16'd0;
                        seq_state = SEQ_SETTLE_ON;
                    end
                end
            end
            SEQ_SETTLE_ON:
            begin
                if (wait_expired({8'd0, settle_reg}))
                begin
                    ctrl_bits[k][B_ON2] = 1'b1;
                    seq_wait  = 16'd0;
                    seq_state = SEQ_WAIT_ACK1;
                end
            end
            SEQ_WAIT_ACK1:
            begin
                if (a1[k])
                begin
                    seq_wait  = 16'd0;
                    seq_state = SEQ_WAIT_ACK2;
                end
                else if (wait_expired(timeout_reg))
                begin
                    result    = OUT_ACK1_TO;
                    seq_wait  = 16'd0;
                    seq_state = SEQ_IDLE;
                end
            end
            SEQ_WAIT_ACK2:
            begin
                if (a2[k])
                begin
                    ctrl_bits[k][B_ISO]   = 1'b0;
                    ctrl_bits[k][B_L1PDN] = 1'b0;
                    seq_wait  = 16'd0;
                    seq_state = SEQ_WAIT_L1;
                end
                else if (wait_expired(timeout_reg))
                begin
                    result    = OUT_ACK2_TO;
                    seq_wait  = 16'd0;
                    seq_state = SEQ_IDLE;
                end
            end
            SEQ_WAIT_L1:
            begin
                if (!l1[k])
                begin
                    seq_wait  = 16'd0;
                    seq_state = SEQ_SETTLE_RST;
                end
                else if (wait_expired(timeout_reg))
                begin
                    result    = OUT_L1_TO;
                    seq_wait  = 16'd0;
                    seq_state = SEQ_IDLE;
                end
            end
            SEQ_SETTLE_RST:
            begin
                if (wait_expired({8'd0, settle_reg}))
                begin
                    ctrl_bits[k][B_ISOINT_B] = 1'b1;
                    ctrl_bits[k][B_CKISO]    = 1'b0;
                    ctrl_bits[k][B_CLKDIS]   = 1'b0;
                    ctrl_bits[k][B_RST_B]    = 1'b1;
                    result    = OUT_DONE;
                    seq_wait  = 16'd0;
                    seq_state = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_state = SEQ_IDLE;
                seq_wait  = 16'd0;
            end
        endcase
        for (int i = 0; i < SLOTS; i++)
            r.control_word[8*i +: 8] = ctrl_bits[i];
        r.busy_res    = (seq_state != SEQ_IDLE);
        r.active_core = seq_core;
        r.outcome     = result;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input logic m, input logic [7:0] c, input logic [3:0] a1,
                                input logic [3:0] a2, input logic [3:0] l1,
                                input bit typed, input res_t want);
        int unsigned gap;
        res_t        predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        core       <= c;
        first_ack  <= a1;
        second_ack <= a2;
        l1_ack     <= l1;
        do @(posedge clk); while (in_stall);
        predicted = step_power_sequence(m, c, a1, a2, l1);
        pending_status_q.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_TIMEOUT)
            timeout_reg = data;
        else
            settle_reg = data[7:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = pick_gap();
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{control_word, busy_res, active_core, outcome};
            if (pending_status_q.size() == 0)
            begin
                report_mismatch("unrequested result", got.control_word, 32'd0);
            end
            else
            begin
                want = pending_status_q.pop_front();
                if (got.control_word !== want.control_word)
                    report_mismatch("control_word", got.control_word, want.control_word);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                if (got.active_core !== want.active_core)
                    report_mismatch("active_core", 32'(got.active_core),
                                    32'(want.active_core));
                if (got.outcome !== want.outcome)
                    report_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
            end
        end
    end

    initial
    begin
        logic       m;
        logic [7:0] c;
        logic [3:0] a1;
        logic [3:0] a2;
        logic [3:0] l1;
        bit         good;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_TIMEOUT;
        cfg_data   = 16'd0;
        in_valid   = 1'b0;
        mode       = 1'b0;
        core       = 8'd0;
        first_ack  = 4'd0;
        second_ack = 4'd0;
        l1_ack     = 4'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].core, directed_rows[i].a1,
                         directed_rows[i].a2, directed_rows[i].l1, directed_rows[i].typed,
                         directed_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_TIMEOUT, timeout_set[p][15:0]);
            write_reg(REG_SETTLE, {8'($urandom), settle_set[p][7:0]});
            quiet = quiet_set[p];
            for (int unsigned n = 0; n < count_set[p]; n++)
            begin
                if (seq_state == SEQ_IDLE)
                    m = ($urandom_range(0, 99) < 60);
                else
                    m = ($urandom_range(0, 99) < 15);
                c  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                a1 = 4'($urandom);
                a2 = 4'($urandom);
                l1 = 4'($urandom);
                // bias the running core's acks; leave some ticks as pure noise
                if ($urandom_range(0, 9) != 0)
                begin
                    good = ($urandom_range(0, 99) < bias_set[p]);
                    a1[seq_core] = good;
                    a2[seq_core] = good;
                    l1[seq_core] = !good;
                end
                send_request(m, c, a1, a2, l1, 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
